/* rtl/core/cpe_pkg.sv */
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types, widths and codes for the contour point extractor.
// ----------------------------------------------------------------------------
package cpe_pkg;

    // Grid geometry
    localparam int GRID_COLUMNS = 128;
    localparam int GRID_ROWS    = 128;
    localparam int COL_W        = $clog2(GRID_COLUMNS);
    localparam int ROW_W        = $clog2(GRID_ROWS);
    localparam int IDX_W        = (COL_W > ROW_W) ? COL_W : ROW_W;

    // Field widths
    localparam int SAMPLE_W     = 24;
    localparam int PITCH_W      = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int FRAC_W       = 18;
    localparam int FRAC_SHIFT   = 12;
    localparam int POS_W        = 19;
    localparam int KIND_W       = 2;
    localparam int OUT_TDATA_W  = ((2 * POS_W + 7) / 8) * 8;

    // Divider sizing: numerator is |a| scaled by 2^12, quotient kept to 19 bits
    localparam int NM_W         = SAMPLE_W + FRAC_SHIFT;
    localparam int Q_W          = 19;
    localparam int DIV_CNT_W    = $clog2(Q_W);

    // Fraction saturation bounds
    localparam int FRAC_MAX     = 131071;
    localparam int FRAC_MIN_MAG = 131072;
    localparam int FRAC_HALF    = 2048;

    // Coordinate arithmetic
    localparam int PROD_W       = FRAC_W + PITCH_W + 1;
    localparam int BASE_W       = IDX_W + PITCH_W;
    localparam int OFS_W        = PROD_W - FRAC_SHIFT;
    localparam int SUM_W        = ((BASE_W > OFS_W) ? BASE_W : OFS_W) + 2;
    localparam int POS_MIN      = -65536;
    localparam int POS_MAX      = 262143;

    // Register reset value (6.25 pixels)
    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(1600);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 1'b1;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_CLOSE = 2'd2
    } t_kind;

    // Main sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_CLASS,
        ST_DIV_X,
        ST_DIV_Y,
        ST_PX_BASE,
        ST_PX_OFF,
        ST_PX_SUM,
        ST_PY_BASE,
        ST_PY_OFF,
        ST_PY_SUM,
        ST_EMIT_PT,
        ST_WR_PREV,
        ST_WR_LAST,
        ST_EMIT_CL
    } t_state;

    // Divider sequencer
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_INIT,
        DV_ITER,
        DV_DONE
    } t_div_state;

endpackage

/* rtl/core/contour_point_extractor.sv */
// Timing: a sample that closes no crossing cell skips the divider and the
// coordinate states; a crossing cell also waits on the shared radix-2 divider
// for two fractions per point. The block takes one sample at a time and drops
// ready until that sample is done; the frame's last sample also emits a close
// marker, and a sink that holds off a waiting result stalls the sequencer.
// Reset (i_rst_n low, synchronous) clears counters, the held sample and the
// output valid flag and loads both pitches with 1600.
// ----------------------------------------------------------------------------
// contour_point_extractor
// Marching-squares point extraction over a raster stream of field samples,
// with a line buffer, a shared divider and a shared multiplier.
// ----------------------------------------------------------------------------
module contour_point_extractor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [cpe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cpe_pkg::CFG_W-1:0]         i_cfg_data,
    // Sample stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [cpe_pkg::SAMPLE_W-1:0]      i_s_tdata,   // [23:0] sample
    // Point stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [cpe_pkg::OUT_TDATA_W-1:0]   o_m_tdata,   // [18:0] x_pos, [37:19] y_pos
    output logic [cpe_pkg::KIND_W-1:0]        o_m_tuser,   // [1:0] kind
    output logic                              o_m_tlast
);

    localparam logic [cpe_pkg::COL_W-1:0] COL_LAST = cpe_pkg::COL_W'(cpe_pkg::GRID_COLUMNS - 1);
    localparam logic [cpe_pkg::ROW_W-1:0] ROW_LAST = cpe_pkg::ROW_W'(cpe_pkg::GRID_ROWS - 1);
    localparam logic signed [cpe_pkg::SUM_W-1:0] POS_LO = cpe_pkg::SUM_W'(cpe_pkg::POS_MIN);
    localparam logic signed [cpe_pkg::SUM_W-1:0] POS_HI = cpe_pkg::SUM_W'(cpe_pkg::POS_MAX);

    cpe_pkg::t_state r_state, n_state;

    // Configuration
    logic [cpe_pkg::PITCH_W-1:0]          r_cell_w;
    logic [cpe_pkg::PITCH_W-1:0]          r_cell_h;

    // Line buffer
    logic [cpe_pkg::SAMPLE_W-1:0]         mem [cpe_pkg::GRID_COLUMNS];
    logic [cpe_pkg::SAMPLE_W-1:0]         r_rdata;
    logic                                 rd_en;
    logic [cpe_pkg::COL_W-1:0]            rd_addr;
    logic                                 wr_en;
    logic [cpe_pkg::COL_W-1:0]            wr_addr;
    logic [cpe_pkg::SAMPLE_W-1:0]         wr_data;

    // Scan state
    logic [cpe_pkg::COL_W-1:0]            r_col;
    logic [cpe_pkg::ROW_W-1:0]            r_row;
    logic                                 r_first;
    logic signed [cpe_pkg::SAMPLE_W-1:0]  r_prior;
    logic signed [cpe_pkg::SAMPLE_W-1:0]  r_s;
    logic signed [cpe_pkg::SAMPLE_W-1:0]  r_a;

    // Point datapath
    logic signed [cpe_pkg::FRAC_W-1:0]    r_fx;
    logic signed [cpe_pkg::FRAC_W-1:0]    r_fy;
    logic signed [cpe_pkg::PROD_W-1:0]    r_prod;
    logic [cpe_pkg::BASE_W-1:0]           r_base;
    logic [cpe_pkg::POS_W-1:0]            r_x;
    logic [cpe_pkg::POS_W-1:0]            r_y;

    // Output register
    logic                                 r_ovalid;
    cpe_pkg::t_kind                       r_okind;
    logic [cpe_pkg::POS_W-1:0]            r_ox;
    logic [cpe_pkg::POS_W-1:0]            r_oy;
    logic                                 r_olast;

    // Combinational controls
    logic                                 accept;
    logic                                 can_load;
    logic                                 out_load;
    cpe_pkg::t_kind                       out_kind;
    logic [cpe_pkg::POS_W-1:0]            out_x;
    logic [cpe_pkg::POS_W-1:0]            out_y;
    logic                                 out_last;
    logic                                 div_start;
    logic signed [cpe_pkg::SAMPLE_W-1:0]  div_a;
    logic signed [cpe_pkg::SAMPLE_W-1:0]  div_e;
    logic                                 div_done;
    logic signed [cpe_pkg::FRAC_W-1:0]    div_quot;
    logic signed [cpe_pkg::FRAC_W-1:0]    mul_a;
    logic signed [cpe_pkg::PITCH_W:0]     mul_b;
    logic signed [cpe_pkg::PROD_W-1:0]    mul_p;
    logic [cpe_pkg::COL_W-1:0]            col_m1;
    logic [cpe_pkg::ROW_W-1:0]            row_m1;
    logic                                 frame_end;
    logic                                 crossing;
    logic signed [cpe_pkg::PROD_W-1:0]    prod_rnd;
    logic signed [cpe_pkg::OFS_W-1:0]     ofs;
    logic signed [cpe_pkg::SUM_W-1:0]     pos_sum;
    logic [cpe_pkg::POS_W-1:0]            pos_sat;

    assign accept    = i_s_tvalid && o_s_tready;
    assign can_load  = !r_ovalid || i_m_tready;
    assign col_m1    = r_col - 1'b1;
    assign row_m1    = r_row - 1'b1;
    assign frame_end = (r_col == COL_LAST) && (r_row == ROW_LAST);

    // Sign case: skip cells with all corners on one side
    always_comb begin
        logic [3:0] cs;
        cs       = {r_prior[cpe_pkg::SAMPLE_W-1], r_s[cpe_pkg::SAMPLE_W-1],
                    r_rdata[cpe_pkg::SAMPLE_W-1], r_a[cpe_pkg::SAMPLE_W-1]};
        crossing = (cs != 4'b0000) && (cs != 4'b1111);
    end

    // Shared multiplier
    assign mul_p = mul_a * mul_b;

    // Round, add base and saturate a coordinate
    assign prod_rnd = r_prod + cpe_pkg::PROD_W'(cpe_pkg::FRAC_HALF);
    assign ofs      = prod_rnd[cpe_pkg::PROD_W-1:cpe_pkg::FRAC_SHIFT];
    assign pos_sum  = $signed(cpe_pkg::SUM_W'(r_base)) + cpe_pkg::SUM_W'(ofs);

    always_comb begin
        if (pos_sum < POS_LO) begin
            pos_sat = POS_LO[cpe_pkg::POS_W-1:0];
        end else if (pos_sum > POS_HI) begin
            pos_sat = POS_HI[cpe_pkg::POS_W-1:0];
        end else begin
            pos_sat = pos_sum[cpe_pkg::POS_W-1:0];
        end
    end

    // Shared divider
    cpe_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (div_a),
        .i_e     (div_e),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w <= cpe_pkg::PITCH_RESET;
            r_cell_h <= cpe_pkg::PITCH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cpe_pkg::CFG_CELL_WIDTH:  r_cell_w <= i_cfg_data;
                cpe_pkg::CFG_CELL_HEIGHT: r_cell_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Line buffer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cpe_pkg::ST_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_first  <= 1'b1;
            r_prior  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Advance the scan after the line buffer update
            if (r_state == cpe_pkg::ST_WR_LAST) begin
                r_prior <= r_s;
                if (r_col == COL_LAST) begin
                    r_col <= '0;
                    r_row <= (r_row == ROW_LAST) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
                if (frame_end) r_first <= 1'b1;
            end
            if ((r_state == cpe_pkg::ST_EMIT_PT) && can_load) begin
                r_first <= 1'b0;
            end
            // Hold the result until the sink takes it
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (accept) r_s <= i_s_tdata;
        if (r_state == cpe_pkg::ST_RD_B) r_a <= r_rdata;
        if ((r_state == cpe_pkg::ST_DIV_X) && div_done) r_fx <= div_quot;
        if ((r_state == cpe_pkg::ST_DIV_Y) && div_done) r_fy <= div_quot;
        if ((r_state == cpe_pkg::ST_PX_OFF) || (r_state == cpe_pkg::ST_PY_OFF)) begin
            r_base <= r_prod[cpe_pkg::BASE_W-1:0];
        end
        if (r_state == cpe_pkg::ST_PX_SUM) r_x <= pos_sat;
        if (r_state == cpe_pkg::ST_PY_SUM) r_y <= pos_sat;
        if (out_load) begin
            r_okind <= out_kind;
            r_ox    <= out_x;
            r_oy    <= out_y;
            r_olast <= out_last;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpe_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = ((r_col != '0) && (r_row != '0)) ? cpe_pkg::ST_RD_A
                                                               : cpe_pkg::ST_WR_PREV;
                end
            end
            cpe_pkg::ST_RD_A:    n_state = cpe_pkg::ST_RD_B;
            cpe_pkg::ST_RD_B:    n_state = cpe_pkg::ST_CLASS;
            cpe_pkg::ST_CLASS: begin
                n_state = crossing ? cpe_pkg::ST_DIV_X : cpe_pkg::ST_WR_PREV;
            end
            cpe_pkg::ST_DIV_X: begin
                if (div_done) n_state = cpe_pkg::ST_DIV_Y;
            end
            cpe_pkg::ST_DIV_Y: begin
                if (div_done) n_state = cpe_pkg::ST_PX_BASE;
            end
            cpe_pkg::ST_PX_BASE: n_state = cpe_pkg::ST_PX_OFF;
            cpe_pkg::ST_PX_OFF:  n_state = cpe_pkg::ST_PX_SUM;
            cpe_pkg::ST_PX_SUM:  n_state = cpe_pkg::ST_PY_BASE;
            cpe_pkg::ST_PY_BASE: n_state = cpe_pkg::ST_PY_OFF;
            cpe_pkg::ST_PY_OFF:  n_state = cpe_pkg::ST_PY_SUM;
            cpe_pkg::ST_PY_SUM:  n_state = cpe_pkg::ST_EMIT_PT;
            cpe_pkg::ST_EMIT_PT: begin
                if (can_load) n_state = cpe_pkg::ST_WR_PREV;
            end
            cpe_pkg::ST_WR_PREV: n_state = cpe_pkg::ST_WR_LAST;
            cpe_pkg::ST_WR_LAST: begin
                n_state = frame_end ? cpe_pkg::ST_EMIT_CL : cpe_pkg::ST_IDLE;
            end
            cpe_pkg::ST_EMIT_CL: begin
                if (can_load) n_state = cpe_pkg::ST_IDLE;
            end
            default: begin
                n_state = cpe_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_tready = (r_state == cpe_pkg::ST_IDLE);
        rd_en      = 1'b0;
        rd_addr    = col_m1;
        wr_en      = 1'b0;
        wr_addr    = col_m1;
        wr_data    = r_prior;
        div_start  = 1'b0;
        div_a      = r_a;
        div_e      = r_prior;
        mul_a      = r_fx;
        mul_b      = {1'b0, r_cell_w};
        out_load   = 1'b0;
        out_kind   = r_first ? cpe_pkg::KIND_START : cpe_pkg::KIND_LINE;
        out_x      = r_x;
        out_y      = r_y;
        out_last   = !frame_end;
        case (r_state)
            cpe_pkg::ST_RD_A: begin
                rd_en   = 1'b1;
                rd_addr = col_m1;
            end
            cpe_pkg::ST_RD_B: begin
                rd_en   = 1'b1;
                rd_addr = r_col;
            end
            cpe_pkg::ST_CLASS: begin
                // Top edge fraction: a to b
                div_start = crossing;
                div_a     = r_a;
                div_e     = r_rdata;
            end
            cpe_pkg::ST_DIV_X: begin
                // Left edge fraction: a to d
                div_start = div_done;
                div_a     = r_a;
                div_e     = r_prior;
            end
            cpe_pkg::ST_PX_BASE: begin
                mul_a = cpe_pkg::FRAC_W'(col_m1);
                mul_b = {1'b0, r_cell_w};
            end
            cpe_pkg::ST_PX_OFF: begin
                mul_a = r_fx;
                mul_b = {1'b0, r_cell_w};
            end
            cpe_pkg::ST_PY_BASE: begin
                mul_a = cpe_pkg::FRAC_W'(row_m1);
                mul_b = {1'b0, r_cell_h};
            end
            cpe_pkg::ST_PY_OFF: begin
                mul_a = r_fy;
                mul_b = {1'b0, r_cell_h};
            end
            cpe_pkg::ST_EMIT_PT: begin
                out_load = can_load;
            end
            cpe_pkg::ST_WR_PREV: begin
                wr_en   = (r_col != '0);
                wr_addr = col_m1;
                wr_data = r_prior;
            end
            cpe_pkg::ST_WR_LAST: begin
                wr_en   = (r_col == COL_LAST);
                wr_addr = r_col;
                wr_data = r_s;
            end
            cpe_pkg::ST_EMIT_CL: begin
                out_load = can_load;
                out_kind = cpe_pkg::KIND_CLOSE;
                out_x    = '0;
                out_y    = '0;
                out_last = 1'b1;
            end
            default: ;
        endcase
    end

    // Drive the point stream
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = cpe_pkg::OUT_TDATA_W'({r_oy, r_ox});
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

endmodule

/* rtl/core/cpe_divider.sv */
// ----------------------------------------------------------------------------
// cpe_divider
// Radix-2 restoring divider for the zero-crossing fraction -a*4096/(e-a),
// truncated toward zero and saturated to signed Q6.12.
// ----------------------------------------------------------------------------
module cpe_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [cpe_pkg::SAMPLE_W-1:0] i_a,
    input  logic signed [cpe_pkg::SAMPLE_W-1:0] i_e,
    output logic                                o_done,
    output logic signed [cpe_pkg::FRAC_W-1:0]   o_quot
);

    cpe_pkg::t_div_state r_state, n_state;

    logic [cpe_pkg::SAMPLE_W-1:0]  r_amag;
    logic [cpe_pkg::SAMPLE_W-1:0]  r_dmag;
    logic                          r_neg;
    logic                          r_eq;
    logic                          r_ovf;
    logic [cpe_pkg::SAMPLE_W-1:0]  r_rem;
    logic [cpe_pkg::Q_W-1:0]       r_q;
    logic [cpe_pkg::DIV_CNT_W-1:0] r_cnt;

    logic [cpe_pkg::SAMPLE_W-1:0]  amag_in;
    logic [cpe_pkg::SAMPLE_W:0]    diff;
    logic [cpe_pkg::SAMPLE_W:0]    diff_mag;
    logic                          a_pos;
    logic [cpe_pkg::NM_W-1:0]      nm;
    logic [cpe_pkg::SAMPLE_W-1:0]  nm_hi;
    logic [cpe_pkg::SAMPLE_W:0]    rem_sh;
    logic [cpe_pkg::SAMPLE_W:0]    rem_sub;
    logic                          ge;

    // Operand magnitudes and signs at start
    assign amag_in  = i_a[cpe_pkg::SAMPLE_W-1] ? (~i_a + 1'b1) : i_a;
    assign diff     = {i_e[cpe_pkg::SAMPLE_W-1], i_e} - {i_a[cpe_pkg::SAMPLE_W-1], i_a};
    assign diff_mag = diff[cpe_pkg::SAMPLE_W] ? (~diff + 1'b1) : diff;
    assign a_pos    = !i_a[cpe_pkg::SAMPLE_W-1] && (i_a != '0);

    // Scaled numerator; its upper part seeds the remainder
    assign nm    = {r_amag, {cpe_pkg::FRAC_SHIFT{1'b0}}};
    assign nm_hi = cpe_pkg::SAMPLE_W'(nm[cpe_pkg::NM_W-1:cpe_pkg::Q_W]);

    // One restoring step
    assign rem_sh  = {r_rem, r_q[cpe_pkg::Q_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dmag};
    assign ge      = (rem_sh >= {1'b0, r_dmag});

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpe_pkg::DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_amag <= amag_in;
            r_dmag <= diff_mag[cpe_pkg::SAMPLE_W-1:0];
            r_neg  <= a_pos ^ diff[cpe_pkg::SAMPLE_W];
            r_eq   <= (i_a == i_e);
        end else if (r_state == cpe_pkg::DV_INIT) begin
            r_rem <= nm_hi;
            r_q   <= nm[cpe_pkg::Q_W-1:0];
            r_ovf <= (nm_hi >= r_dmag);
            r_cnt <= cpe_pkg::DIV_CNT_W'(cpe_pkg::Q_W - 1);
        end else if (r_state == cpe_pkg::DV_ITER) begin
            r_rem <= ge ? rem_sub[cpe_pkg::SAMPLE_W-1:0] : rem_sh[cpe_pkg::SAMPLE_W-1:0];
            r_q   <= {r_q[cpe_pkg::Q_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpe_pkg::DV_IDLE: begin
                if (i_start) n_state = cpe_pkg::DV_INIT;
            end
            cpe_pkg::DV_INIT: begin
                n_state = cpe_pkg::DV_ITER;
            end
            cpe_pkg::DV_ITER: begin
                if (r_cnt == '0) n_state = cpe_pkg::DV_DONE;
            end
            cpe_pkg::DV_DONE: begin
                n_state = i_start ? cpe_pkg::DV_INIT : cpe_pkg::DV_IDLE;
            end
            default: begin
                n_state = cpe_pkg::DV_IDLE;
            end
        endcase
    end

    // Outputs: sign, saturation and the equal-corners case
    always_comb begin
        o_done = (r_state == cpe_pkg::DV_DONE);
        if (r_eq) begin
            o_quot = cpe_pkg::FRAC_W'(cpe_pkg::FRAC_HALF);
        end else if (!r_neg) begin
            if (r_ovf || (r_q > cpe_pkg::Q_W'(cpe_pkg::FRAC_MAX))) begin
                o_quot = cpe_pkg::FRAC_W'(cpe_pkg::FRAC_MAX);
            end else begin
                o_quot = r_q[cpe_pkg::FRAC_W-1:0];
            end
        end else begin
            if (r_ovf || (r_q > cpe_pkg::Q_W'(cpe_pkg::FRAC_MIN_MAG))) begin
                o_quot = cpe_pkg::FRAC_W'(cpe_pkg::FRAC_MIN_MAG);
            end else begin
                o_quot = ~r_q[cpe_pkg::FRAC_W-1:0] + 1'b1;
            end
        end
    end

endmodule

/* rtl/core/cpe_checker.sv */
// ----------------------------------------------------------------------------
// cpe_checker
// Port-level checks for the contour point extractor, bound to the top level.
// ----------------------------------------------------------------------------
module cpe_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [cpe_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input logic [cpe_pkg::KIND_W-1:0]        o_m_tuser,
    input logic                              o_m_tlast
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // Close marker carries no position and ends the request
    a_close_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == cpe_pkg::KIND_CLOSE) |-> (o_m_tdata == '0) && o_m_tlast)
        else $error("malformed close marker");

    // One sample at a time: ready drops after an accepted request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready held after accepted request");

    // Reset leaves the block idle with an empty output register
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid && o_s_tready)
        else $error("not idle after reset");

endmodule

bind contour_point_extractor cpe_checker u_cpe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for contour_point_extractor. Field samples are streamed
// in raster order. A scoreboard rebuilds the line buffer, the sign case and
// the fixed-point interpolation of each crossing cell, and it checks every
// point and every close marker in order. Phases vary the pitch registers and
// the idling on both stream sides. One phase holds the output for a long
// stretch so that the input stalls.
// ----------------------------------------------------------------------------
module testbench;
    import cpe_pkg::*;

    // Wait for trailing sample work after the last point
    localparam int SETTLE_CYCLES = 64;
    // Hang guard for ~1.9k samples at their worst case, plus the hold-off, x3
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int MAX_GAP = 40;
    localparam int HOLD_OFF_CYCLES = 3000;

    typedef struct {
        t_kind            kind;
        logic [POS_W-1:0] x_pos;
        logic [POS_W-1:0] y_pos;
        logic             is_last;
    } point_t;

    // Predicts the point stream and checks the block against it
    class contour_scoreboard;
        int unsigned                width_q8;
        int unsigned                height_q8;
        logic signed [SAMPLE_W-1:0] line_buf [GRID_COLUMNS];
        logic signed [SAMPLE_W-1:0] held;
        int unsigned                col_cnt;
        int unsigned                row_cnt;
        bit                         need_start;
        point_t                     due_points [$];
        int unsigned                errors;
        int unsigned                samples_seen;
        int unsigned                points_seen;
        int unsigned                closes_seen;

        function new();
            width_q8 = PITCH_RESET;
            height_q8 = PITCH_RESET;
            foreach (line_buf[i])
                line_buf[i] = '0;
            held = '0;
            col_cnt = 0;
            row_cnt = 0;
            need_start = 1'b1;
            errors = 0;
            samples_seen = 0;
            points_seen = 0;
            closes_seen = 0;
        endfunction

        function void write_pitch(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_CELL_WIDTH) begin
                width_q8 = value;
            end else begin
                height_q8 = value;
            end
        endfunction

        // Zero crossing along edge a->e in Q6.12, truncated toward zero
        function longint edge_fraction(longint a, longint e);
            longint q;
            if (a == e)
                return FRAC_HALF;
            q = (-a * 4096) / (e - a);
            if (q > FRAC_MAX)
                q = FRAC_MAX;
            if (q < -FRAC_MIN_MAG)
                q = -FRAC_MIN_MAG;
            return q;
        endfunction

        // Cell origin plus rounded offset, saturated to the coordinate range
        function logic [POS_W-1:0] grid_coord(int unsigned index, int unsigned pitch,
                                              longint frac);
            longint p;
            p = longint'(index) * longint'(pitch)
                + ((longint'(pitch) * frac + FRAC_HALF) >>> FRAC_SHIFT);
            if (p < POS_MIN)
                p = POS_MIN;
            if (p > POS_MAX)
                p = POS_MAX;
            return p[POS_W-1:0];
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            int unsigned                col;
            int unsigned                row;
            int unsigned                n;
            logic signed [SAMPLE_W-1:0] a;
            logic signed [SAMPLE_W-1:0] b;
            logic [3:0]                 neg_corners;
            point_t                     pt;
            col = col_cnt;
            row = row_cnt;
            n = 0;
            samples_seen++;
            if (col > 0) begin
                if (row > 0) begin
                    a = line_buf[col-1];
                    b = line_buf[col];
                    neg_corners = {held < 0, s < 0, b < 0, a < 0};
                    // Emit one point unless all corners agree in sign
                    if (neg_corners != 4'h0 && neg_corners != 4'hF) begin
                        if (need_start) begin
                            pt.kind = KIND_START;
                        end else begin
                            pt.kind = KIND_LINE;
                        end
                        pt.x_pos = grid_coord(col - 1, width_q8, edge_fraction(a, b));
                        pt.y_pos = grid_coord(row - 1, height_q8, edge_fraction(a, held));
                        pt.is_last = 1'b0;
                        due_points.push_back(pt);
                        need_start = 1'b0;
                        n++;
                    end
                end
                line_buf[col-1] = held;
            end
            if (col == GRID_COLUMNS - 1)
                line_buf[col] = s;
            held = s;
            // Advance raster position; the frame's last sample closes the path
            if (col == GRID_COLUMNS - 1 && row == GRID_ROWS - 1) begin
                pt.kind = KIND_CLOSE;
                pt.x_pos = '0;
                pt.y_pos = '0;
                pt.is_last = 1'b0;
                due_points.push_back(pt);
                n++;
                col_cnt = 0;
                row_cnt = 0;
                need_start = 1'b1;
            end else if (col == GRID_COLUMNS - 1) begin
                col_cnt = 0;
                row_cnt = row + 1;
            end else begin
                col_cnt = col + 1;
            end
            if (n > 0)
                due_points[due_points.size()-1].is_last = 1'b1;
        endfunction

        function void check_point(logic [KIND_W-1:0] kind, logic [POS_W-1:0] x,
                                  logic [POS_W-1:0] y, logic is_last);
            point_t want;
            if (due_points.size() == 0) begin
                $error("unexpected result: kind %0d x_pos %0d y_pos %0d",
                       kind, $signed(x), $signed(y));
                errors++;
                return;
            end
            want = due_points.pop_front();
            if (kind != want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (x != want.x_pos) begin
                $error("x_pos: expected %0d, got %0d", $signed(want.x_pos), $signed(x));
                errors++;
            end
            if (y != want.y_pos) begin
                $error("y_pos: expected %0d, got %0d", $signed(want.y_pos), $signed(y));
                errors++;
            end
            if (is_last != want.is_last) begin
                $error("last: expected %0d, got %0d", want.is_last, is_last);
                errors++;
            end
            if (want.kind == KIND_CLOSE) begin
                closes_seen++;
            end else begin
                points_seen++;
            end
        endfunction
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;

    contour_scoreboard sb;
    int unsigned       idle_pct  = 0;
    int unsigned       stall_pct = 0;
    int unsigned       hold_left = 0;
    int unsigned       cycle_cnt = 0;

    contour_point_extractor u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Check each accepted result, then pick the next ready (hold-off first)
    always @(posedge clk) begin
        if (rst_n && m_tready && m_tvalid)
            sb.check_point(m_tuser, m_tdata[POS_W-1:0], m_tdata[2*POS_W-1:POS_W], m_tlast);
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one sample after a random gap and hold it until the request is taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do @(posedge clk); while (!s_tready);
        sb.note_sample(v);
    endtask

    // Drop the request and wait until the block has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.due_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pitches(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_CELL_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx <= CFG_CELL_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_pitch(CFG_CELL_WIDTH, w);
        sb.write_pitch(CFG_CELL_HEIGHT, h);
    endtask

    // First two rows: hand-built cells in the leading columns, positive filler after
    function automatic logic [SAMPLE_W-1:0] directed_sample(int unsigned row,
                                                            int unsigned col);
        int top;
        int below;
        case (col)
            0: begin top = 100;      below = -8388608; end
            1: begin top = -8388608; below = 8388607;  end  // full-scale top edge
            2: begin top = 8388607;  below = -1;       end
            3: begin top = -5;       below = 0;        end
            4: begin top = -5;       below = 7;        end  // equal top corners
            5: begin top = -100000;  below = 3;        end
            6: begin top = -99999;   below = -2;       end  // fraction saturates high
            7: begin top = 100000;   below = -3;       end
            8: begin top = 100001;   below = -4;       end  // fraction saturates low
            9: begin top = 0;        below = 5;        end
            10: begin top = 0;       below = 0;        end  // no corner inside
            11: begin top = -7;      below = -9;       end
            12: begin top = -8;      below = -10;      end  // all corners inside
            default: begin
                top = $urandom_range(8388607);
                below = $urandom_range(8388607);
            end
        endcase
        return SAMPLE_W'((row == 0) ? top : below);
    endfunction

    // Mix wide values, values near zero, extremes and repeats (equal corners)
    function automatic logic [SAMPLE_W-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 35)
            return SAMPLE_W'($urandom());
        if (pick < 65)
            return SAMPLE_W'($urandom_range(600)) - SAMPLE_W'(300);
        if (pick < 75) begin
            case ($urandom_range(3))
                0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
                1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
                2: return '0;
                default: return '1;
            endcase
        end
        if (pick < 88)
            return sb.held;
        return sb.line_buf[sb.col_cnt];
    endfunction

    task automatic run_random(input int unsigned count);
        repeat (count) send_sample(random_sample());
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Hand-built cells under the reset pitches, no idling
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < GRID_COLUMNS; c++)
                send_sample(directed_sample(r, c));
        run_random(300);

        // Unit width, full-scale height, sender mostly idle
        settle();
        set_pitches(1, 16'hFFFF);
        idle_pct = 75;
        run_random(300);

        // Full-scale width, unit height, receiver mostly stalled after a long hold
        settle();
        set_pitches(16'hFFFF, 1);
        idle_pct = 0;
        stall_pct = 75;
        hold_left = HOLD_OFF_CYCLES;
        run_random(300);

        // Zero pitches, light idling on both sides
        settle();
        set_pitches(0, 0);
        idle_pct = 8;
        stall_pct = 8;
        run_random(250);

        settle();
        set_pitches(CFG_W'($urandom_range(65535, 1)), CFG_W'($urandom_range(65535, 1)));
        idle_pct = 0;
        stall_pct = 0;
        run_random(300);

        // Random pitches again, light idling on both sides
        settle();
        set_pitches(CFG_W'($urandom_range(65535, 1)), CFG_W'($urandom_range(65535, 1)));
        idle_pct = 8;
        stall_pct = 8;
        run_random(150);
        settle();

        $display("Streamed %0d samples; checked %0d contour points and %0d path closes.",
                 sb.samples_seen, sb.points_seen, sb.closes_seen);
        $display("Pitches covered reset, unit, full-scale, zero and random values.");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/cpe_pkg.sv
rtl/core/cpe_divider.sv
rtl/core/contour_point_extractor.sv
rtl/core/cpe_checker.sv
verif/testbench.sv
